FILE: src/deadline_timer_queue_assert.svh
// Assertion macros for the deadline timer queue top level.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define DTQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define DTQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define DTQ_ASSERT(lbl, expr, msg)
`define DTQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: src/dtq_pkg.sv
// Types and constants for the deadline timer queue.
package dtq_pkg;

  localparam int ID_BITS         = 4;
  localparam int ID_COUNT        = 16;
  localparam int TIME_FIELD_BITS = 48;
  localparam int TIME_MAX_BITS   = 64;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_SET_OK       = 3'd0,
    KIND_SET_FULL     = 3'd1,
    KIND_REMOVED      = 3'd2,
    KIND_NOT_FOUND    = 3'd3,
    KIND_EXPIRED      = 3'd4,
    KIND_NONE_EXPIRED = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic [TIME_FIELD_BITS-1:0] time_value;
    logic [ID_BITS-1:0]         timer_id;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [ID_BITS-1:0] result_id;
    logic               last;
  } res_item_t;

  // Update request from the back engine to the slot store
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic               pop;
    logic [ID_BITS-1:0] id;
  } slot_op_t;

  typedef struct packed {
    logic               full;
    logic               found;
    logic               due0;
    logic               due1;
    logic [ID_BITS-1:0] free_id;
    logic [ID_BITS-1:0] head_id;
  } slot_status_t;

endpackage

FILE: src/dtq_front.sv
// Front end: accepts command transfers, drops unused codes, queues the rest.
module dtq_front #(
  parameter int TIME_BITS = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  dtq_pkg::cmd_item_t      cmd_data,
  output logic                    head_valid,
  output dtq_pkg::cmd_t           head_cmd,
  output logic [TIME_BITS-1:0]    head_time,
  output logic [dtq_pkg::ID_BITS-1:0] head_id,
  input  logic                    head_pop
);
  import dtq_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  cmd_t                 q_cmd  [QDEPTH];
  logic [TIME_BITS-1:0] q_time [QDEPTH];
  logic [ID_BITS-1:0]   q_id   [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic [TIME_MAX_BITS-1:0] t_wide;
  cmd_t                 in_cmd;
  logic                 push;
  logic                 pop;

  assign t_wide    = TIME_MAX_BITS'(cmd_data.time_value);
  assign in_cmd    = cmd_t'(cmd_data.cmd);
  assign cmd_stall = (count == CNT_W'(QDEPTH));
  // unused command code is taken and discarded
  assign push      = cmd_valid && !cmd_stall && (in_cmd != CMD_NONE);
  assign head_valid = (count != '0);
  assign pop       = head_pop && head_valid;

  assign head_cmd  = q_cmd[rd_ptr];
  assign head_time = q_time[rd_ptr];
  assign head_id   = q_id[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr]  <= in_cmd;
      q_time[wr_ptr] <= t_wide[TIME_BITS-1:0];
      q_id[wr_ptr]   <= cmd_data.timer_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

FILE: src/dtq_slots.sv
// Sorted slot store: deadlines kept ascending, with identifier allocation.
module dtq_slots #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dtq_pkg::slot_op_t     op,
  input  logic [TIME_BITS-1:0]  op_time,
  output dtq_pkg::slot_status_t status
);
  import dtq_pkg::*;

  localparam int OCC_W = $clog2(SLOTS + 1);

  logic [TIME_BITS-1:0] deadline [SLOTS];
  logic [ID_BITS-1:0]   ident    [SLOTS];
  logic [OCC_W-1:0]     occ;
  logic [ID_COUNT-1:0]  in_use;
  logic [SLOTS-1:0]     live;
  logic [SLOTS-1:0]     ge;
  logic [SLOTS-1:0]     first;
  logic [SLOTS-1:0]     match;
  logic [SLOTS-1:0]     sel;
  logic [SLOTS-1:0]     above;
  logic [ID_BITS-1:0]   free_id;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      live[i]  = OCC_W'(i) < occ;
      // new entry lands ahead of equal deadlines
      ge[i]    = !live[i] || (deadline[i] >= op_time);
      match[i] = live[i] && (ident[i] == op.id);
      sel[i]   = op.pop ? (i == 0) : match[i];
    end
    for (int i = 0; i < SLOTS; i++) begin
      first[i] = ge[i];
      if (i > 0) first[i] = ge[i] && !ge[i-1];
      above[i] = 1'b0;
      for (int j = 0; j <= i; j++) above[i] = above[i] | sel[j];
    end
  end

  always_comb begin
    free_id = '0;
    for (int k = ID_COUNT - 1; k >= 0; k--) begin
      if (!in_use[k]) free_id = ID_BITS'(k);
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    logic [TIME_BITS-1:0] prev_d;
    logic [ID_BITS-1:0]   prev_i;
    logic [TIME_BITS-1:0] nxt_d;
    logic [ID_BITS-1:0]   nxt_i;
    if (g == 0) begin : g_lo
      assign prev_d = op_time;
      assign prev_i = free_id;
    end else begin : g_mid
      assign prev_d = deadline[g-1];
      assign prev_i = ident[g-1];
    end
    if (g == SLOTS - 1) begin : g_hi
      assign nxt_d = deadline[g];
      assign nxt_i = ident[g];
    end else begin : g_below
      assign nxt_d = deadline[g+1];
      assign nxt_i = ident[g+1];
    end

    always_ff @(posedge clk) begin
      if (op.ins) begin
        if (first[g]) begin
          deadline[g] <= op_time;
          ident[g]    <= free_id;
        end else if (ge[g]) begin
          deadline[g] <= prev_d;
          ident[g]    <= prev_i;
        end
      end else if (op.rem || op.pop) begin
        if (above[g]) begin
          deadline[g] <= nxt_d;
          ident[g]    <= nxt_i;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      in_use <= '0;
    end else if (op.ins) begin
      occ             <= occ + OCC_W'(1);
      in_use[free_id] <= 1'b1;
    end else if (op.rem) begin
      occ           <= occ - OCC_W'(1);
      in_use[op.id] <= 1'b0;
    end else if (op.pop) begin
      occ              <= occ - OCC_W'(1);
      in_use[ident[0]] <= 1'b0;
    end
  end

  assign status.full    = (occ == OCC_W'(SLOTS));
  assign status.found   = |match;
  assign status.due0    = live[0] && (deadline[0] <= op_time);
  assign status.due1    = live[1] && (deadline[1] <= op_time);
  assign status.free_id = free_id;
  assign status.head_id = ident[0];

endmodule

FILE: src/dtq_back.sv
// Back engine: executes queued commands against the slot store, registers results.
module dtq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  dtq_pkg::cmd_t               head_cmd,
  input  logic [dtq_pkg::ID_BITS-1:0] head_id,
  output logic                        head_pop,
  input  dtq_pkg::slot_status_t       status,
  output dtq_pkg::slot_op_t           op,
  output logic                        res_valid,
  input  logic                        res_stall,
  output dtq_pkg::res_item_t          res_data
);
  import dtq_pkg::*;

  logic      fire;
  logic      emit;
  res_item_t res;

  assign fire = head_valid && (!res_valid || !res_stall);

  always_comb begin
    res      = '0;
    emit     = 1'b0;
    head_pop = 1'b0;
    op       = '0;
    op.id    = head_id;
    if (fire) begin
      unique case (head_cmd)
        CMD_SET: begin
          emit     = 1'b1;
          head_pop = 1'b1;
          res.last = 1'b1;
          if (status.full) begin
            res.kind = KIND_SET_FULL;
          end else begin
            res.kind      = KIND_SET_OK;
            res.result_id = status.free_id;
            op.ins        = 1'b1;
          end
        end
        CMD_REMOVE: begin
          emit          = 1'b1;
          head_pop      = 1'b1;
          res.last      = 1'b1;
          res.result_id = head_id;
          if (status.found) begin
            res.kind = KIND_REMOVED;
            op.rem   = 1'b1;
          end else begin
            res.kind = KIND_NOT_FOUND;
          end
        end
        CMD_TICK: begin
          emit = 1'b1;
          // one expiry per cycle unless stalled; tick retires with last due entry
          if (status.due0) begin
            res.kind      = KIND_EXPIRED;
            res.result_id = status.head_id;
            res.last      = !status.due1;
            op.pop        = 1'b1;
            head_pop      = !status.due1;
          end else begin
            res.kind = KIND_NONE_EXPIRED;
            res.last = 1'b1;
            head_pop = 1'b1;
          end
        end
        CMD_NONE: begin
          head_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) res_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

FILE: src/deadline_timer_queue.sv
// Top level of the deadline timer queue.
// Holds up to min(DEPTH, 16) pending timers sorted by deadline. A command
// transfer goes into a two-entry queue and is executed by the back engine,
// so commands keep flowing in while a result waits on the output register.
// Set and remove each give one result; a tick gives one per expired
// timer, at least one, since the slot store updates once a cycle and the
// output register takes one result a cycle. With an unstalled output and
// a queued command, the back engine delivers a result every cycle.
// Unused code 3 is taken, with no result. No clearing pass after reset.
`include "deadline_timer_queue_assert.svh"
module deadline_timer_queue #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  dtq_pkg::cmd_item_t cmd_data,
  output logic               res_valid,
  input  logic               res_stall,
  output dtq_pkg::res_item_t res_data
);
  import dtq_pkg::*;

  // only 16 identifiers exist, so no more slots can ever fill
  localparam int SLOTS = (DEPTH < ID_COUNT) ? DEPTH : ID_COUNT;

  logic                 head_valid;
  cmd_t                 head_cmd;
  logic [TIME_BITS-1:0] head_time;
  logic [ID_BITS-1:0]   head_id;
  logic                 head_pop;
  slot_op_t             op;
  slot_status_t         status;

  dtq_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .head_time (head_time),
    .head_id   (head_id),
    .head_pop  (head_pop)
  );

  dtq_slots #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_slots (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .op_time(head_time),
    .status (status)
  );

  dtq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .head_id   (head_id),
    .head_pop  (head_pop),
    .status    (status),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  `DTQ_ASSERT(a_one_op, $onehot0({op.ins, op.rem, op.pop}), "more than one slot update")
  `DTQ_ASSERT_IMPLY(a_ins_room, op.ins, !status.full, "insert into full store")
  `DTQ_ASSERT_IMPLY(a_pop_due, op.pop, status.due0, "expiry of an entry not due")
  `DTQ_ASSERT_IMPLY(a_stall_head, cmd_stall, head_valid, "queue full without a head")

endmodule

FILE: tb/dtq_checker.sv
// Checker for the deadline timer queue: tracks pending timers and checks every result transfer.
`timescale 1ns / 100ps
module dtq_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  dtq_pkg::cmd_item_t cmd_data,
  input  logic               res_valid,
  input  logic               res_stall,
  input  dtq_pkg::res_item_t res_data,
  output int                 errors,
  output int                 pending
);
  import dtq_pkg::*;

  localparam int SLOTS = 16;

  // Timers sorted by deadline, earliest in slot 0
  logic [TIME_FIELD_BITS-1:0] deadline_q [SLOTS];
  logic [ID_BITS-1:0]         owner_q    [SLOTS];
  int                         armed;
  logic [ID_COUNT-1:0]        id_busy;
  res_item_t                  due_results [$];

  function automatic void push_result(kind_t k, logic [ID_BITS-1:0] id, logic fin);
    res_item_t r;
    r.kind      = k;
    r.result_id = id;
    r.last      = fin;
    due_results.push_back(r);
  endfunction

  function automatic void drop_timer(int pos);
    logic [ID_BITS-1:0] id;
    id = owner_q[pos];
    for (int i = pos; i + 1 < armed; i++) begin
      deadline_q[i] = deadline_q[i+1];
      owner_q[i]    = owner_q[i+1];
    end
    armed--;
    id_busy[id] = 1'b0;
  endfunction

  function automatic void run_timer_cmd(cmd_item_t c);
    int free_id;
    int pos;
    int hits;
    free_id = -1;
    pos     = 0;
    hits    = 0;
    case (cmd_t'(c.cmd))
      CMD_SET: begin
        for (int i = ID_COUNT - 1; i >= 0; i--)
          if (!id_busy[i]) free_id = i;
        if (armed >= SLOTS || free_id < 0) begin
          push_result(KIND_SET_FULL, '0, 1'b1);
        end else begin
          // new timer goes ahead of equal deadlines
          while (pos < armed && deadline_q[pos] < c.time_value) pos++;
          for (int i = armed; i > pos; i--) begin
            deadline_q[i] = deadline_q[i-1];
            owner_q[i]    = owner_q[i-1];
          end
          deadline_q[pos] = c.time_value;
          owner_q[pos]    = ID_BITS'(free_id);
          armed++;
          id_busy[free_id] = 1'b1;
          push_result(KIND_SET_OK, ID_BITS'(free_id), 1'b1);
        end
      end
      CMD_REMOVE: begin
        while (pos < armed && owner_q[pos] != c.timer_id) pos++;
        if (pos < armed) begin
          drop_timer(pos);
          push_result(KIND_REMOVED, c.timer_id, 1'b1);
        end else begin
          push_result(KIND_NOT_FOUND, c.timer_id, 1'b1);
        end
      end
      CMD_TICK: begin
        while (armed > 0 && deadline_q[0] <= c.time_value && hits < ID_COUNT) begin
          push_result(KIND_EXPIRED, owner_q[0], 1'b0);
          drop_timer(0);
          hits++;
        end
        if (hits == 0) begin
          push_result(KIND_NONE_EXPIRED, '0, 1'b1);
        end else begin
          due_results[due_results.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    res_item_t want;
    if (rst) begin
      armed   = 0;
      id_busy = '0;
      errors  = 0;
      due_results.delete();
    end else begin
      // results are registered, so a result never belongs to this edge's command
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unrequested result: expected nothing, got kind %0d id %0d last %0b",
                   $time, res_data.kind, res_data.result_id, res_data.last);
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (res_data.kind !== want.kind || res_data.result_id !== want.result_id ||
              res_data.last !== want.last) begin
            errors++;
            $display("%0t: mismatch exp kind %0d id %0d last %0b got kind %0d id %0d last %0b",
                     $time, want.kind, want.result_id, want.last,
                     res_data.kind, res_data.result_id, res_data.last);
          end
        end
      end
      if (cmd_valid && !cmd_stall) run_timer_cmd(cmd_data);
    end
    pending = due_results.size();
  end

endmodule

FILE: tb/tb_deadline_timer_queue.sv
// Testbench top for the deadline timer queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_deadline_timer_queue;
  import dtq_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [TIME_FIELD_BITS-1:0] TIME_TOP = '1;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd_data;
  logic      res_valid;
  logic      res_stall;
  res_item_t res_data;
  int        errors;
  int        pending;
  logic      calm;
  logic      hold_req;
  int        quiet_cycles;
  logic [TIME_FIELD_BITS-1:0] now;

  deadline_timer_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  dtq_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit held;
    held = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        res_stall <= !calm && ($urandom_range(99) < 10);
      end
    end
  end

  function automatic logic [TIME_FIELD_BITS-1:0] rand_time();
    return {16'($urandom()), $urandom()};
  endfunction

  task automatic send_cmd(cmd_t op, logic [TIME_FIELD_BITS-1:0] t, logic [ID_BITS-1:0] id);
    cmd_item_t item;
    item.cmd        = op;
    item.time_value = t;
    item.timer_id   = id;
    while (!calm && $urandom_range(99) < 10) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= item;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int made;
    int pick;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd_data  <= '0;
    calm      <= 1'b0;
    hold_req  <= 1'b0;
    now = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, unused code, extremes, equal deadlines, reuse of ids
    send_cmd(CMD_TICK, '0, '0);
    send_cmd(CMD_REMOVE, '0, 4'hf);
    send_cmd(CMD_NONE, TIME_TOP, 4'hf);
    send_cmd(CMD_SET, '0, '0);
    send_cmd(CMD_SET, TIME_TOP, '0);
    send_cmd(CMD_SET, 48'd100, '0);
    send_cmd(CMD_SET, 48'd100, '0);
    send_cmd(CMD_SET, '0, '0);
    send_cmd(CMD_TICK, '0, '0);
    send_cmd(CMD_REMOVE, '0, 4'd1);
    send_cmd(CMD_REMOVE, TIME_TOP, 4'd1);
    send_cmd(CMD_SET, 48'd5, '0);
    send_cmd(CMD_TICK, 48'd99, '0);
    send_cmd(CMD_TICK, 48'd100, '0);
    send_cmd(CMD_TICK, TIME_TOP, '0);
    send_cmd(CMD_SET, TIME_TOP, '0);
    send_cmd(CMD_TICK, TIME_TOP, 4'hf);
    send_cmd(CMD_TICK, '0, '0);
    wait_drained();

    // Fill past capacity while results are held off, then expire everything at once
    hold_req <= 1'b1;
    for (int i = 0; i <= ID_COUNT; i++)
      send_cmd(CMD_SET, $urandom_range(1) ? TIME_FIELD_BITS'($urandom_range(7)) : rand_time(),
               ID_BITS'($urandom()));
    send_cmd(CMD_TICK, TIME_TOP, '0);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      calm <= (made >= 20 && made < 50);
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_cmd(CMD_SET, ($urandom_range(19) == 0) ? rand_time() : now + $urandom_range(60),
                 ID_BITS'($urandom()));
        made++;
      end else if (pick < 65) begin
        send_cmd(CMD_REMOVE, rand_time(), ID_BITS'($urandom_range(15)));
        made++;
      end else if (pick < 93) begin
        now = now + $urandom_range(40);
        send_cmd(CMD_TICK, now, ID_BITS'($urandom()));
        made++;
      end else if (pick < 96) begin
        send_cmd(CMD_TICK, rand_time(), ID_BITS'($urandom()));
        made++;
      end else begin
        send_cmd(CMD_NONE, rand_time(), ID_BITS'($urandom()));
      end
    end

    cmd_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/dtq_pkg.sv
src/dtq_front.sv
src/dtq_slots.sv
src/dtq_back.sv
src/deadline_timer_queue.sv
tb/dtq_checker.sv
tb/tb_deadline_timer_queue.sv
